// ----- design/rbd_pkg.sv -----
`timescale 1ns / 1ps

package rbd_pkg;

  localparam int unsigned ValueBits = 32;
  localparam int unsigned OccBits   = 9;
  localparam int unsigned FuncBits  = 3;

  typedef enum logic [FuncBits-1:0] {
    FUNC_PUSH_FRONT = 3'd0,
    FUNC_PUSH_BACK  = 3'd1,
    FUNC_POP_FRONT  = 3'd2,
    FUNC_POP_BACK   = 3'd3,
    FUNC_PEEK_FRONT = 3'd4,
    FUNC_PEEK_BACK  = 3'd5
  } func_e;

  typedef enum logic [1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    logic               valid;
    logic               rd;
    status_e            status;
    logic [OccBits-1:0] occupancy;
    logic               is_empty;
    logic               is_full;
  } rsp_t;

endpackage

// ----- design/rbd_ram.sv -----
`timescale 1ns / 1ps

module rbd_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/rbd_ctrl.sv -----
`timescale 1ns / 1ps

module rbd_ctrl
  import rbd_pkg::*;
#(
  parameter int unsigned DEPTH     = 256,
  parameter int unsigned WORD_BITS = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     req_i,
  input  func_e                    func_i,
  input  logic [WORD_BITS-1:0]     wdata_i,
  output logic                     mem_we_o,
  output logic [$clog2(DEPTH)-1:0] mem_waddr_o,
  output logic [WORD_BITS-1:0]     mem_wdata_o,
  output logic [$clog2(DEPTH)-1:0] mem_raddr_o,
  output rsp_t                     rsp_o
);

  localparam int unsigned AddrBits = $clog2(DEPTH);
  localparam int unsigned CntBits  = $clog2(DEPTH + 1);
  localparam logic [AddrBits-1:0] LastIdx = AddrBits'(DEPTH - 1);
  localparam logic [CntBits-1:0]  FullCnt = CntBits'(DEPTH);

  logic [AddrBits-1:0] front_q, front_d;
  logic [AddrBits-1:0] back_q, back_d;
  logic [CntBits-1:0]  cnt_q, cnt_d;
  rsp_t                rsp_q, rsp_d;

  logic                is_full, is_empty;
  logic [AddrBits-1:0] front_inc, front_dec, back_inc, back_dec;

  assign is_full   = (cnt_q == FullCnt);
  assign is_empty  = (cnt_q == '0);
  assign front_inc = (front_q == LastIdx) ? '0 : front_q + AddrBits'(1);
  assign front_dec = (front_q == '0) ? LastIdx : front_q - AddrBits'(1);
  assign back_inc  = (back_q == LastIdx) ? '0 : back_q + AddrBits'(1);
  assign back_dec  = (back_q == '0) ? LastIdx : back_q - AddrBits'(1);

  always_comb begin
    front_d     = front_q;
    back_d      = back_q;
    cnt_d       = cnt_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = front_dec;
    mem_wdata_o = wdata_i;
    mem_raddr_o = front_q;
    rsp_d       = '0;
    rsp_d.status = STATUS_DONE;

    if (req_i) begin
      rsp_d.valid = 1'b1;
      unique case (func_i)
        FUNC_PUSH_FRONT: begin
          if (is_full) begin
            rsp_d.status = STATUS_FULL;
          end else begin
            front_d     = front_dec;
            mem_we_o    = 1'b1;
            mem_waddr_o = front_dec;
            cnt_d       = cnt_q + CntBits'(1);
          end
        end
        FUNC_PUSH_BACK: begin
          if (is_full) begin
            rsp_d.status = STATUS_FULL;
          end else begin
            back_d      = back_inc;
            mem_we_o    = 1'b1;
            mem_waddr_o = back_inc;
            cnt_d       = cnt_q + CntBits'(1);
          end
        end
        FUNC_POP_FRONT, FUNC_PEEK_FRONT: begin
          if (is_empty) begin
            rsp_d.status = STATUS_EMPTY;
          end else begin
            rsp_d.rd    = 1'b1;
            mem_raddr_o = front_q;
            if (func_i == FUNC_POP_FRONT) begin
              front_d = front_inc;
              cnt_d   = cnt_q - CntBits'(1);
            end
          end
        end
        FUNC_POP_BACK, FUNC_PEEK_BACK: begin
          if (is_empty) begin
            rsp_d.status = STATUS_EMPTY;
          end else begin
            rsp_d.rd    = 1'b1;
            mem_raddr_o = back_q;
            if (func_i == FUNC_POP_BACK) begin
              back_d = back_dec;
              cnt_d  = cnt_q - CntBits'(1);
            end
          end
        end
        default: begin
        end
      endcase
    end

    rsp_d.occupancy = OccBits'(cnt_d);
    rsp_d.is_empty  = (cnt_d == '0);
    rsp_d.is_full   = (cnt_d == FullCnt);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
      back_q  <= LastIdx;
      cnt_q   <= '0;
      rsp_q   <= '0;
    end else begin
      front_q <= front_d;
      back_q  <= back_d;
      cnt_q   <= cnt_d;
      rsp_q   <= rsp_d;
    end
  end

  assign rsp_o = rsp_q;

endmodule

// ----- design/ring_buffer_deque.sv -----
// Double-ended queue of words in a circular single-port-write, registered-read memory.
// The result strobe done_o is registered and rises in the cycle after a request is accepted.
// Throughput: one request per cycle; pointers and count update in the accept cycle and
// the memory read data arrives the next cycle, so busy is never raised.
// Reset: empty, front index zero, back index DEPTH-1; memory contents are not cleared.
`timescale 1ns / 1ps

module ring_buffer_deque_core
  import rbd_pkg::*;
#(
  parameter int unsigned DEPTH     = 256,
  parameter int unsigned WORD_BITS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic [FuncBits-1:0]  func_i,
  input  logic [ValueBits-1:0] write_value_i,
  output logic                 done_o,
  output logic [ValueBits-1:0] read_value_o,
  output logic [1:0]           status_o,
  output logic [OccBits-1:0]   occupancy_o,
  output logic                 is_empty_o,
  output logic                 is_full_o
);

  localparam int unsigned AddrBits = $clog2(DEPTH);

  logic                 req;
  logic                 mem_we;
  logic [AddrBits-1:0]  mem_waddr;
  logic [WORD_BITS-1:0] mem_wdata;
  logic [AddrBits-1:0]  mem_raddr;
  logic [WORD_BITS-1:0] mem_rdata;
  rsp_t                 rsp;

  assign busy = 1'b0;
  assign req  = start && !busy;

  rbd_ctrl #(
    .DEPTH    (DEPTH),
    .WORD_BITS(WORD_BITS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req),
    .func_i     (func_e'(func_i)),
    .wdata_i    (WORD_BITS'(write_value_i)),
    .mem_we_o   (mem_we),
    .mem_waddr_o(mem_waddr),
    .mem_wdata_o(mem_wdata),
    .mem_raddr_o(mem_raddr),
    .rsp_o      (rsp)
  );

  rbd_ram #(
    .WIDTH(WORD_BITS),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  assign done_o       = rsp.valid;
  assign read_value_o = rsp.rd ? ValueBits'(mem_rdata) : '0;
  assign status_o     = rsp.status;
  assign occupancy_o  = rsp.occupancy;
  assign is_empty_o   = rsp.is_empty;
  assign is_full_o    = rsp.is_full;

  a_done_follows_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req |=> done_o)
    else $error("Accepted request produced no result strobe.");

  a_reject_reads_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != STATUS_DONE) |-> read_value_o == '0)
    else $error("Rejected request returned a nonzero word.");

  a_full_reject_is_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == STATUS_FULL) |-> is_full_o)
    else $error("Push rejected as full while the deque is not full.");

  a_empty_reject_is_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == STATUS_EMPTY) |-> is_empty_o)
    else $error("Request rejected as empty while the deque holds words.");

  a_not_both_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(is_empty_o && is_full_o))
    else $error("Empty and full flags both set.");

endmodule

// ----- verif/ring_buffer_deque_checker.sv -----
`timescale 1ns / 1ps

module ring_buffer_deque_checker
  import rbd_pkg::*;
#(
  parameter int unsigned DEPTH = 256
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic                 busy_i,
  input  logic [FuncBits-1:0]  func_i,
  input  logic [ValueBits-1:0] write_value_i,
  input  logic                 done_i,
  input  logic [ValueBits-1:0] read_value_i,
  input  logic [1:0]           status_i,
  input  logic [OccBits-1:0]   occupancy_i,
  input  logic                 is_empty_i,
  input  logic                 is_full_i,
  output int unsigned          fail_count_o,
  output int unsigned          pending_o
);

  localparam int unsigned IdxBits = $clog2(DEPTH);
  localparam logic [IdxBits-1:0] LastIdx = IdxBits'(DEPTH - 1);

  typedef struct packed {
    logic [ValueBits-1:0] read_value;
    status_e              status;
    logic [OccBits-1:0]   occupancy;
    logic                 is_empty;
    logic                 is_full;
  } deque_result_t;

  logic [ValueBits-1:0] words [DEPTH];
  logic [IdxBits-1:0]   head_idx;
  logic [IdxBits-1:0]   tail_idx;
  int unsigned          word_total;
  int unsigned          fails;
  deque_result_t        awaited_results[$];

  function automatic deque_result_t deque_apply(logic [FuncBits-1:0] func,
                                                logic [ValueBits-1:0] value);
    deque_result_t res;
    res = '0;
    res.status = STATUS_DONE;
    case (func)
      FUNC_PUSH_FRONT, FUNC_PUSH_BACK: begin
        if (word_total >= DEPTH) begin
          res.status = STATUS_FULL;
        end else if (func == FUNC_PUSH_FRONT) begin
          head_idx = (head_idx == '0) ? LastIdx : head_idx - IdxBits'(1);
          words[head_idx] = value;
          word_total++;
        end else begin
          tail_idx = (tail_idx == LastIdx) ? '0 : tail_idx + IdxBits'(1);
          words[tail_idx] = value;
          word_total++;
        end
      end
      FUNC_POP_FRONT, FUNC_PEEK_FRONT: begin
        if (word_total == 0) begin
          res.status = STATUS_EMPTY;
        end else begin
          res.read_value = words[head_idx];
          if (func == FUNC_POP_FRONT) begin
            head_idx = (head_idx == LastIdx) ? '0 : head_idx + IdxBits'(1);
            word_total--;
          end
        end
      end
      FUNC_POP_BACK, FUNC_PEEK_BACK: begin
        if (word_total == 0) begin
          res.status = STATUS_EMPTY;
        end else begin
          res.read_value = words[tail_idx];
          if (func == FUNC_POP_BACK) begin
            tail_idx = (tail_idx == '0) ? LastIdx : tail_idx - IdxBits'(1);
            word_total--;
          end
        end
      end
      default: begin
      end
    endcase
    res.occupancy = word_total[OccBits-1:0];
    res.is_empty  = (word_total == 0);
    res.is_full   = (word_total >= DEPTH);
    return res;
  endfunction

  function automatic void compare_field(string name, logic [ValueBits-1:0] want,
                                        logic [ValueBits-1:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      fails++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    deque_result_t want;
    if (!rst_ni) begin
      head_idx = '0;
      tail_idx = LastIdx;
      word_total = 0;
      fails = 0;
      awaited_results.delete();
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (start_i && !busy_i) begin
        awaited_results.push_back(deque_apply(func_i, write_value_i));
      end
      if (done_i) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: result with no request outstanding, expected none actual %0h",
                   $time, read_value_i);
          fails++;
        end else begin
          want = awaited_results.pop_front();
          compare_field("read_value", want.read_value, read_value_i);
          compare_field("status", ValueBits'(want.status), ValueBits'(status_i));
          compare_field("occupancy", ValueBits'(want.occupancy), ValueBits'(occupancy_i));
          compare_field("is_empty", ValueBits'(want.is_empty), ValueBits'(is_empty_i));
          compare_field("is_full", ValueBits'(want.is_full), ValueBits'(is_full_i));
        end
      end
      fail_count_o <= fails;
      pending_o <= awaited_results.size();
    end
  end

endmodule

// ----- verif/tb_ring_buffer_deque_core.sv -----
`timescale 1ns / 1ps

module tb_ring_buffer_deque_core
  import rbd_pkg::*;
();

  localparam int unsigned Depth      = 256;
  localparam int unsigned StallLimit = 2000;
  localparam logic [FuncBits-1:0] FUNC_SPARE_LO = 3'd6;
  localparam logic [FuncBits-1:0] FUNC_SPARE_HI = 3'd7;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 start;
  logic                 busy;
  logic [FuncBits-1:0]  func_i;
  logic [ValueBits-1:0] write_value_i;
  logic                 done_o;
  logic [ValueBits-1:0] read_value_o;
  logic [1:0]           status_o;
  logic [OccBits-1:0]   occupancy_o;
  logic                 is_empty_o;
  logic                 is_full_o;
  int unsigned          fail_count;
  int unsigned          pending;
  int unsigned          stall_cycles;
  int unsigned          sent;
  int unsigned          full_hits;
  int unsigned          empty_hits;

  ring_buffer_deque_core #(
    .DEPTH    (Depth),
    .WORD_BITS(ValueBits)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .func_i       (func_i),
    .write_value_i(write_value_i),
    .done_o       (done_o),
    .read_value_o (read_value_o),
    .status_o     (status_o),
    .occupancy_o  (occupancy_o),
    .is_empty_o   (is_empty_o),
    .is_full_o    (is_full_o)
  );

  ring_buffer_deque_checker #(
    .DEPTH(Depth)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .busy_i       (busy),
    .func_i       (func_i),
    .write_value_i(write_value_i),
    .done_i       (done_o),
    .read_value_i (read_value_o),
    .status_i     (status_o),
    .occupancy_i  (occupancy_o),
    .is_empty_i   (is_empty_o),
    .is_full_i    (is_full_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || done_o) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
      if (done_o && is_full_o) begin
        full_hits <= full_hits + 1;
      end
      if (done_o && is_empty_o) begin
        empty_hits <= empty_hits + 1;
      end
      if (stall_cycles >= StallLimit) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  task automatic send_request(logic [FuncBits-1:0] func, logic [ValueBits-1:0] value);
    @(negedge clk_i);
    // The sender runs back to back for a while early in the fill phase.
    while (!(sent >= 40 && sent < 160) && $urandom_range(99) < 13) begin
      start <= 1'b0;
      func_i <= FuncBits'($urandom_range(7));
      write_value_i <= $urandom;
      @(negedge clk_i);
    end
    start <= 1'b1;
    func_i <= func;
    write_value_i <= value;
    do begin
      @(posedge clk_i);
    end while (busy);
    sent++;
  endtask

  task automatic send_random(int unsigned push_pct);
    int unsigned pick;
    logic [FuncBits-1:0] func;
    pick = $urandom_range(99);
    if ($urandom_range(99) < push_pct) begin
      func = $urandom_range(1) ? FUNC_PUSH_BACK : FUNC_PUSH_FRONT;
    end else if (pick < 85) begin
      func = $urandom_range(1) ? FUNC_POP_BACK : FUNC_POP_FRONT;
    end else if (pick < 95) begin
      func = $urandom_range(1) ? FUNC_PEEK_BACK : FUNC_PEEK_FRONT;
    end else begin
      func = $urandom_range(1) ? FUNC_SPARE_HI : FUNC_SPARE_LO;
    end
    send_request(func, $urandom);
  endtask

  initial begin
    int unsigned mark;
    rst_ni = 1'b0;
    start = 1'b0;
    func_i = FUNC_PUSH_FRONT;
    write_value_i = '0;
    stall_cycles = 0;
    sent = 0;
    full_hits = 0;
    empty_hits = 0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_request(FUNC_PEEK_FRONT, 32'h0000_0000);
    send_request(FUNC_PEEK_BACK, 32'hFFFF_FFFF);
    send_request(FUNC_POP_FRONT, 32'h1234_5678);
    send_request(FUNC_POP_BACK, 32'h8765_4321);
    send_request(FUNC_SPARE_LO, 32'hFFFF_FFFF);
    send_request(FUNC_SPARE_HI, 32'hFFFF_FFFF);
    send_request(FUNC_PUSH_FRONT, 32'h0000_0000);
    send_request(FUNC_PUSH_BACK, 32'hFFFF_FFFF);
    send_request(FUNC_SPARE_LO, 32'h0000_0000);
    send_request(FUNC_PEEK_FRONT, 32'h0000_0000);
    send_request(FUNC_PEEK_BACK, 32'h0000_0000);
    send_request(FUNC_POP_BACK, 32'h0000_0000);
    send_request(FUNC_POP_FRONT, 32'h0000_0000);
    send_request(FUNC_PUSH_BACK, 32'hA5A5_A5A5);
    send_request(FUNC_PUSH_FRONT, 32'h5A5A_5A5A);
    send_request(FUNC_POP_FRONT, 32'h0000_0000);
    send_request(FUNC_POP_BACK, 32'h0000_0000);
    send_request(FUNC_POP_BACK, 32'h0000_0000);
    send_request(FUNC_PEEK_FRONT, 32'h0000_0000);

    // Fill until the deque has reported full a number of times, so that
    // rejected pushes and wraparound of both indices are exercised.
    mark = full_hits;
    while (full_hits < mark + 5) begin
      send_random(96);
    end
    mark = empty_hits;
    while (empty_hits < mark + 5) begin
      send_random(2);
    end
    repeat (20) begin
      send_random(50);
    end

    @(negedge clk_i);
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
